[sv/lbs_pkg.sv]
// ============================================================================
// lbs_pkg
// Shared sizes and types for the longest bitonic subsequence engine.
// ============================================================================
package lbs_pkg;

    localparam int MAX_LEN    = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int OUT_W      = 7;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_HEAD  = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

endpackage

[sv/longest_bitonic_subsequence.sv]
// ============================================================================
// longest_bitonic_subsequence
// Stores a sequence of signed values, then runs the increasing and decreasing
// subsequence passes with one shared comparator and reports the lengths.
// ============================================================================
//
//  channel | dir | tdata / tuser                                   | tlast
//  --------+-----+-------------------------------------------------+-------------
//  s_      | in  | tdata[31:0] value                               | last element
//  m_      | out | tdata: bitonic, increasing, decreasing lengths; | none
//          |     | tuser: overflow                                 |
//
//  Loading accepts one element per cycle. After the last element, the rise
//  and fall passes each visit every position i in a head, fetch and write
//  state, scanning one compared element per cycle between fetch and write;
//  the single comparator over the element memory read port sets the pace.
//  s_tready is low meanwhile. A finished result waits in the output register
//  while the next sequence loads. Reset clears the state, pass flag, count,
//  drop flag and output valid; the memories are not cleared.
//
module longest_bitonic_subsequence
    import lbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [6:0] bitonic_length,
                                              // [13:7] increasing_length,
                                              // [20:14] decreasing_length,
                                              // [23:21] zero
    output logic                   m_tuser    // [0] overflow
);

    logic [DATA_WIDTH-1:0] elem_mem [MAX_LEN];
    logic [LEN_W-1:0]      rise_mem [MAX_LEN];
    logic [LEN_W-1:0]      fall_mem [MAX_LEN];

    state_t                state_reg, state_next;
    logic                  fall_pass_reg, fall_pass_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  dropped_reg, dropped_next;
    logic                  ovf_res_reg, ovf_res_next;
    logic [IDX_W-1:0]      last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [DATA_WIDTH-1:0] cur_key_reg, cur_key_next;
    logic [LEN_W-1:0]      cur_len_reg, cur_len_next;
    logic [LEN_W-1:0]      rise_i_reg, rise_i_next;
    logic [LEN_W-1:0]      best_rise_reg, best_rise_next;
    logic [LEN_W-1:0]      best_fall_reg, best_fall_next;
    logic [LEN_W-1:0]      best_both_reg, best_both_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_both_reg, out_both_next;
    logic [OUT_W-1:0]      out_rise_reg, out_rise_next;
    logic [OUT_W-1:0]      out_fall_reg, out_fall_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] elem_rd;
    logic [LEN_W-1:0]      rise_rd;
    logic [LEN_W-1:0]      fall_rd;
    logic [LEN_W-1:0]      len_rd;
    logic [IDX_W-1:0]      step_j;
    logic [LEN_W:0]        len_plus;
    logic [LEN_W:0]        both_sum;
    logic [LEN_W-1:0]      both_len;
    logic                  in_xfer;
    logic                  store_en;
    logic [DATA_WIDTH-1:0] in_key;

    assign in_xfer  = s_tvalid && s_tready;
    assign store_en = in_xfer && (count_reg < CNT_W'(MAX_LEN));
    // Flipping the sign bit turns the signed order into the unsigned order.
    assign in_key   = s_tdata[DATA_WIDTH-1:0] ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};

    assign len_rd   = fall_pass_reg ? fall_rd : rise_rd;
    assign step_j   = fall_pass_reg ? j_reg - 1'b1 : j_reg + 1'b1;
    assign len_plus = {1'b0, len_rd} + 1'b1;
    assign both_sum = {1'b0, rise_i_reg} + {1'b0, cur_len_reg} - 1'b1;
    assign both_len = both_sum[LEN_W-1:0];

    always_comb
    begin
        case (state_reg)
            ST_HEAD:  rd_addr = i_reg;
            ST_FETCH: rd_addr = fall_pass_reg ? last_idx_reg : '0;
            ST_SCAN:  rd_addr = step_j;
            default:  rd_addr = i_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            elem_mem[count_reg[IDX_W-1:0]] <= in_key;
        end
        if (state_reg == ST_WRITE && !fall_pass_reg)
        begin
            rise_mem[i_reg] <= cur_len_reg;
        end
        if (state_reg == ST_WRITE && fall_pass_reg)
        begin
            fall_mem[i_reg] <= cur_len_reg;
        end
        elem_rd <= elem_mem[rd_addr];
        rise_rd <= rise_mem[rd_addr];
        fall_rd <= fall_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        fall_pass_next = fall_pass_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        ovf_res_next   = ovf_res_reg;
        last_idx_next  = last_idx_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_key_next   = cur_key_reg;
        cur_len_next   = cur_len_reg;
        rise_i_next    = rise_i_reg;
        best_rise_next = best_rise_reg;
        best_fall_next = best_fall_reg;
        best_both_next = best_both_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_both_next  = out_both_reg;
        out_rise_next  = out_rise_reg;
        out_fall_next  = out_fall_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (store_en)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        // At least one element is stored once last arrives.
                        last_idx_next  = store_en ? count_reg[IDX_W-1:0]
                                                  : IDX_W'(MAX_LEN - 1);
                        ovf_res_next   = dropped_reg || !store_en;
                        count_next     = '0;
                        dropped_next   = 1'b0;
                        fall_pass_next = 1'b0;
                        i_next         = '0;
                        best_rise_next = '0;
                        best_fall_next = '0;
                        best_both_next = '0;
                        state_next     = ST_HEAD;
                    end
                end
            end
            ST_HEAD:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cur_key_next = elem_rd;
                cur_len_next = LEN_W'(1);
                rise_i_next  = rise_rd;
                j_next       = fall_pass_reg ? last_idx_reg : '0;
                if (fall_pass_reg ? (i_reg == last_idx_reg) : (i_reg == '0))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cur_key_reg > elem_rd && {1'b0, cur_len_reg} < len_plus)
                begin
                    cur_len_next = len_plus[LEN_W-1:0];
                end
                j_next = step_j;
                if (step_j == i_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!fall_pass_reg)
                begin
                    if (i_reg == last_idx_reg)
                    begin
                        fall_pass_next = 1'b1;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    state_next = ST_HEAD;
                end
                else
                begin
                    if (rise_i_reg > best_rise_reg)
                    begin
                        best_rise_next = rise_i_reg;
                    end
                    if (cur_len_reg > best_fall_reg)
                    begin
                        best_fall_next = cur_len_reg;
                    end
                    if (both_len > best_both_reg)
                    begin
                        best_both_next = both_len;
                    end
                    if (i_reg == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_both_next  = OUT_W'(best_both_reg);
                    out_rise_next  = OUT_W'(best_rise_reg);
                    out_fall_next  = OUT_W'(best_fall_reg);
                    out_ovf_next   = ovf_res_reg;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fall_pass_reg <= 1'b0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fall_pass_reg <= fall_pass_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_res_reg   <= ovf_res_next;
        last_idx_reg  <= last_idx_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        cur_key_reg   <= cur_key_next;
        cur_len_reg   <= cur_len_next;
        rise_i_reg    <= rise_i_next;
        best_rise_reg <= best_rise_next;
        best_fall_reg <= best_fall_next;
        best_both_reg <= best_both_next;
        out_both_reg  <= out_both_next;
        out_rise_reg  <= out_rise_next;
        out_fall_reg  <= out_fall_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 3 * OUT_W){1'b0}},
                       out_fall_reg, out_rise_reg, out_both_reg};
    assign m_tuser  = out_ovf_reg;

endmodule

[sv/lbs_checker.sv]
// ============================================================================
// lbs_checker
// Port-level checks for the longest bitonic subsequence engine.
// ============================================================================
module lbs_checker
    import lbs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    // A stalled result must hold its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Loading continues after a transfer that is not the last element.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("input stalled during loading");

    // The computation begins right after the last element.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready right after last element");

    // The bitonic length covers both monotonic lengths and is never zero.
    a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:0] != 7'd0 && m_tdata[6:0] >= m_tdata[13:7]
                     && m_tdata[6:0] >= m_tdata[20:14])
        else $error("inconsistent result lengths");

    // The bitonic length stays within the element store size; the other two are never zero.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:0] <= 7'(MAX_LEN) && m_tdata[13:7] != 7'd0
                     && m_tdata[20:14] != 7'd0)
        else $error("result length out of range");

endmodule

bind longest_bitonic_subsequence lbs_checker u_lbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
